/* rtl/agc_pkg.sv */
// agc_pkg: shared types, codes, AES helper functions and a byte mask helper for the AES-GCM core
// depends on nothing; used by agc_key_sched, agc_aes_core and the top level
`default_nettype none
package agc_pkg;

  localparam int unsigned BlkW = 128;
  localparam int unsigned KeyW = 256;
  localparam int unsigned NumRk = 15;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_AAD    = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_TAG    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] CFG_KEY0  = 3'd0;
  localparam logic [2:0] CFG_KEY1  = 3'd1;
  localparam logic [2:0] CFG_KEY2  = 3'd2;
  localparam logic [2:0] CFG_KEY3  = 3'd3;
  localparam logic [2:0] CFG_KSIZE = 3'd4;

  localparam logic [1:0] KSIZE_128 = 2'd0;
  localparam logic [1:0] KSIZE_192 = 2'd1;
  localparam logic [1:0] KSIZE_256 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_HKEY,
    ST_DATA_AES,
    ST_GHASH,
    ST_TAG_MUL,
    ST_TAG_AES,
    ST_OUT
  } agc_state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // sub-bytes and shift-rows, then mix-columns unless last round; byte 0 in the top bits
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int k = 0; k < 16; k++) begin
      sb[k] = s[127 - 8 * k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[w + 4 * c] = SBOX[sb[w + 4 * ((c + w) % 4)]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c];
        a1 = t[4 * c + 1];
        a2 = t[4 * c + 2];
        a3 = t[4 * c + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      r[127 - 8 * k -: 8] = t[k];
    end
    return r;
  endfunction

  // leading n bytes set, n of sixteen or more gives all ones
  function automatic logic [127:0] byte_mask(input logic [4:0] n);
    return ~({128{1'b1}} >> {n, 3'b000});
  endfunction

endpackage
`default_nettype wire

/* rtl/agc_key_sched.sv */
// agc_key_sched: word-serial AES key expansion and the round key store (15 rows of 128 bits)
// depends on agc_pkg
`default_nettype none
module agc_key_sched (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [255:0] key_i,
  input  logic [1:0]   key_size_i,
  output logic         done_o,
  input  logic [3:0]   rd_addr_i,
  output logic [127:0] rd_data_o
);

  logic         run_q;
  logic         done_q;
  logic [5:0]   i_q;
  logic [2:0]   j_q;
  logic [7:0]   rcon_q;
  logic [31:0]  win_q [8];
  logic [127:0] mem_q [agc_pkg::NumRk];
  logic [127:0] rd_q;

  logic [3:0]  nk;
  logic [2:0]  nk_m1;
  logic [5:0]  total;
  logic [31:0] t;
  logic [31:0] w;
  logic [31:0] wr;

  always_comb begin
    unique case (key_size_i)
      agc_pkg::KSIZE_128: begin nk = 4'd4; nk_m1 = 3'd3; total = 6'd44; end
      agc_pkg::KSIZE_192: begin nk = 4'd6; nk_m1 = 3'd5; total = 6'd52; end
      default:            begin nk = 4'd8; nk_m1 = 3'd7; total = 6'd60; end
    endcase
    t = win_q[0];
    if ({2'b00, i_q} < {4'b0000, nk}) begin
      w = key_i[8'd255 - {i_q[2:0], 5'b00000} -: 32];
    end else begin
      if (j_q == 3'd0) begin
        t = agc_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h000000};
      end else if (nk == 4'd8 && j_q == 3'd4) begin
        t = agc_pkg::sub_word(t);
      end
      w = win_q[nk_m1] ^ t;
    end
    wr = (i_q < total) ? w : 32'h0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
      rcon_q <= 8'h01;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        i_q    <= '0;
        j_q    <= '0;
        rcon_q <= 8'h01;
      end else if (run_q) begin
        i_q <= i_q + 6'd1;
        j_q <= (j_q == nk_m1) ? 3'd0 : j_q + 3'd1;
        if ({2'b00, i_q} >= {4'b0000, nk} && j_q == 3'd0) begin
          rcon_q <= agc_pkg::xtime(rcon_q);
        end
        if (i_q == 6'd59) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q && !start_i) begin
      win_q[0] <= w;
      for (int k = 1; k < 8; k++) begin
        win_q[k] <= win_q[k - 1];
      end
      mem_q[i_q[5:2]][7'd127 - {i_q[1:0], 5'b00000} -: 32] <= wr;
    end
    rd_q <= (rd_addr_i < 4'(agc_pkg::NumRk)) ? mem_q[rd_addr_i] : '0;
  end

  assign done_o    = done_q;
  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

/* rtl/agc_aes_core.sv */
// agc_aes_core: iterative AES encryption, one round per cycle, keys read from agc_key_sched
// depends on agc_pkg
`default_nettype none
module agc_aes_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] blk_i,
  input  logic [3:0]   nr_i,
  output logic [3:0]   rk_addr_o,
  input  logic [127:0] rk_i,
  output logic         done_o,
  output logic [127:0] res_o
);

  logic         run_q;
  logic         prime_q;
  logic         done_q;
  logic [3:0]   a_q;
  logic [3:0]   r_q;
  logic [127:0] s_q;
  logic [127:0] s_next;

  // round key for round r arrives while the address counter already points at r+1
  always_comb begin
    if (r_q == 4'd0) begin
      s_next = s_q ^ rk_i;
    end else begin
      s_next = agc_pkg::aes_round(s_q, r_q == nr_i) ^ rk_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      prime_q <= 1'b0;
      done_q  <= 1'b0;
      a_q     <= '0;
      r_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q   <= 1'b1;
        prime_q <= 1'b1;
        a_q     <= '0;
        r_q     <= '0;
      end else if (run_q) begin
        a_q <= a_q + 4'd1;
        if (prime_q) begin
          prime_q <= 1'b0;
        end else begin
          r_q <= r_q + 4'd1;
          if (r_q == nr_i) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q <= blk_i;
    end else if (run_q && !prime_q) begin
      s_q <= s_next;
    end
  end

  assign rk_addr_o = a_q;
  assign done_o    = done_q;
  assign res_o     = s_q;

endmodule
`default_nettype wire

/* rtl/agc_gf_mul.sv */
// agc_gf_mul: GHASH multiply in GF(2^128), eight multiplier bits per cycle
// depends on nothing outside this file
`default_nettype none
module agc_gf_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] x_i,
  input  logic [127:0] y_i,
  output logic         done_o,
  output logic [127:0] z_o
);

  logic         run_q;
  logic         done_q;
  logic [3:0]   cnt_q;
  logic [127:0] acc_q;
  logic [127:0] v_q;
  logic [127:0] x_q;
  logic [127:0] acc_n;
  logic [127:0] v_n;

  always_comb begin
    acc_n = acc_q;
    v_n   = v_q;
    for (int b = 0; b < 8; b++) begin
      if (x_q[127 - b]) begin
        acc_n = acc_n ^ v_n;
      end
      v_n = {1'b0, v_n[127:1]} ^ (v_n[0] ? {8'he1, 120'h0} : 128'h0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      v_q   <= y_i;
      x_q   <= x_i;
    end else if (run_q) begin
      acc_q <= acc_n;
      v_q   <= v_n;
      x_q   <= {x_q[119:0], 8'h00};
    end
  end

  assign done_o = done_q;
  assign z_o    = acc_q;

endmodule
`default_nettype wire

/* rtl/aes_gcm_authenticated_cipher_core.sv */
// aes_gcm_authenticated_cipher_core: top level, sequencer, message state and stream ports
// depends on agc_pkg, agc_key_sched, agc_aes_core, agc_gf_mul
`default_nettype none
// AES-GCM engine for 128, 192 and 256-bit keys. Write the key words and key size, then send a
// start item (IV, direction, tag length), AAD blocks, data blocks and a finish item on the
// input stream; one item is handled at a time and s_axis_tready is low while it is at work.
// A start expands the key one 32-bit word per cycle and then runs AES for H before the next
// item is taken. An AAD block is hashed by the GHASH multiplier, which retires eight bits per
// cycle. A data block runs AES of its counter block on the one-round-per-cycle AES unit (Nr
// rounds, Nr is 10, 12 or 14), then GHASH, and then hands the result to the output register.
// A finish runs GHASH of the lengths first and AES of the counter block after. A result waits
// in the output register until taken; while that register is full the next result is held
// and the block stays busy.
module aes_gcm_authenticated_cipher_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // block_hi [63:0], block_lo [127:64], valid_bytes [132:128], encrypt [133],
  // tag_bytes [138:134], zero fill [143:139]
  input  logic [143:0] s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_hi [63:0], out_lo [127:64], out_bytes [132:128], tag_ok [133], zero fill [135:134]
  output logic [135:0] m_axis_tdata,
  // out_kind [1:0]
  output logic [1:0]   m_axis_tuser
);

  agc_pkg::agc_state_e state_q, state_d;

  logic [63:0]  key_q [4];
  logic [1:0]   ksize_q;
  logic [95:0]  iv_q;
  logic [31:0]  ctr_q;
  logic [127:0] acc_q;
  logic [127:0] h_q;
  logic [60:0]  aad_cnt_q;
  logic [60:0]  dat_cnt_q;
  logic         enc_q;
  logic [4:0]   tlen_q;
  logic [127:0] blk_q;
  logic [127:0] mask_q;
  logic         emit_q;
  logic [127:0] res_q;
  logic [1:0]   res_kind_q;
  logic [4:0]   res_bytes_q;
  logic         res_ok_q;

  logic         out_valid_q;
  logic [1:0]   out_kind_q;
  logic [127:0] out_blk_q;
  logic [4:0]   out_bytes_q;
  logic         out_ok_q;

  logic         in_fire;
  logic [1:0]   in_op;
  logic [127:0] in_blk;
  logic [4:0]   in_nb_raw;
  logic [4:0]   in_nb;
  logic [4:0]   in_tb;
  logic [127:0] in_mask;
  logic [3:0]   nr;

  logic         ks_start;
  logic         ks_done;
  logic [3:0]   rk_addr;
  logic [127:0] rk_row;
  logic         aes_start;
  logic [127:0] aes_blk;
  logic         aes_done;
  logic [127:0] aes_res;
  logic         gf_start;
  logic [127:0] gf_x;
  logic         gf_done;
  logic [127:0] gf_z;

  logic [127:0] data_out;
  logic [127:0] tag_keep;
  logic [127:0] tag_val;

  assign in_op     = s_axis_tuser;
  assign in_blk    = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign in_nb_raw = s_axis_tdata[132:128];
  assign in_nb     = (in_nb_raw > 5'd16) ? 5'd16 : in_nb_raw;
  assign in_tb     = (s_axis_tdata[138:134] == 5'd0 || s_axis_tdata[138:134] > 5'd16) ?
                     5'd16 : s_axis_tdata[138:134];
  assign in_mask   = agc_pkg::byte_mask(in_nb);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == agc_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    unique case (ksize_q)
      agc_pkg::KSIZE_128: nr = 4'd10;
      agc_pkg::KSIZE_192: nr = 4'd12;
      default:            nr = 4'd14;
    endcase
  end

  assign data_out = (blk_q ^ aes_res) & mask_q;
  assign tag_keep = agc_pkg::byte_mask(tlen_q);
  assign tag_val  = (res_q ^ aes_res) & tag_keep;

  always_comb begin
    state_d   = state_q;
    ks_start  = 1'b0;
    aes_start = 1'b0;
    aes_blk   = '0;
    gf_start  = 1'b0;
    gf_x      = '0;
    unique case (state_q)
      agc_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            agc_pkg::OP_START: begin
              ks_start = 1'b1;
              state_d  = agc_pkg::ST_KEXP;
            end
            agc_pkg::OP_AAD: begin
              if (in_nb != 5'd0) begin
                gf_start = 1'b1;
                gf_x     = acc_q ^ (in_blk & in_mask);
                state_d  = agc_pkg::ST_GHASH;
              end
            end
            agc_pkg::OP_DATA: begin
              if (in_nb != 5'd0) begin
                aes_start = 1'b1;
                aes_blk   = {iv_q, ctr_q + 32'd1};
                state_d   = agc_pkg::ST_DATA_AES;
              end
            end
            default: begin
              gf_start = 1'b1;
              gf_x     = acc_q ^ {aad_cnt_q, 3'b000, dat_cnt_q, 3'b000};
              state_d  = agc_pkg::ST_TAG_MUL;
            end
          endcase
        end
      end
      agc_pkg::ST_KEXP: begin
        if (ks_done) begin
          aes_start = 1'b1;
          state_d   = agc_pkg::ST_HKEY;
        end
      end
      agc_pkg::ST_HKEY: begin
        if (aes_done) begin
          state_d = agc_pkg::ST_IDLE;
        end
      end
      agc_pkg::ST_DATA_AES: begin
        if (aes_done) begin
          gf_start = 1'b1;
          gf_x     = acc_q ^ (enc_q ? data_out : (blk_q & mask_q));
          state_d  = agc_pkg::ST_GHASH;
        end
      end
      agc_pkg::ST_GHASH: begin
        if (gf_done) begin
          state_d = emit_q ? agc_pkg::ST_OUT : agc_pkg::ST_IDLE;
        end
      end
      agc_pkg::ST_TAG_MUL: begin
        if (gf_done) begin
          aes_start = 1'b1;
          aes_blk   = {iv_q, 32'd1};
          state_d   = agc_pkg::ST_TAG_AES;
        end
      end
      agc_pkg::ST_TAG_AES: begin
        if (aes_done) begin
          state_d = agc_pkg::ST_OUT;
        end
      end
      agc_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = agc_pkg::ST_IDLE;
        end
      end
      default: state_d = agc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= agc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      key_q[0]    <= '0;
      key_q[1]    <= '0;
      key_q[2]    <= '0;
      key_q[3]    <= '0;
      ksize_q     <= '0;
      iv_q        <= '0;
      ctr_q       <= 32'd1;
      acc_q       <= '0;
      aad_cnt_q   <= '0;
      dat_cnt_q   <= '0;
      enc_q       <= 1'b1;
      tlen_q      <= 5'd16;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          agc_pkg::CFG_KEY0:  key_q[0] <= cfg_data_i;
          agc_pkg::CFG_KEY1:  key_q[1] <= cfg_data_i;
          agc_pkg::CFG_KEY2:  key_q[2] <= cfg_data_i;
          agc_pkg::CFG_KEY3:  key_q[3] <= cfg_data_i;
          agc_pkg::CFG_KSIZE: ksize_q  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (state_q == agc_pkg::ST_OUT && state_d == agc_pkg::ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        unique case (in_op)
          agc_pkg::OP_START: begin
            iv_q      <= in_blk[127:32];
            ctr_q     <= 32'd1;
            acc_q     <= '0;
            aad_cnt_q <= '0;
            dat_cnt_q <= '0;
            enc_q     <= s_axis_tdata[133];
            tlen_q    <= in_tb;
          end
          agc_pkg::OP_AAD: aad_cnt_q <= aad_cnt_q + 61'(in_nb);
          agc_pkg::OP_DATA: begin
            if (in_nb != 5'd0) begin
              ctr_q     <= ctr_q + 32'd1;
              dat_cnt_q <= dat_cnt_q + 61'(in_nb);
            end
          end
          default: ;
        endcase
      end
      if (state_q == agc_pkg::ST_GHASH && gf_done) begin
        acc_q <= gf_z;
      end
    end
  end

  // byte count of a leading-ones byte mask
  function automatic logic [4:0] in_nb_q_bytes(input logic [127:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int k = 0; k < 16; k++) begin
      n = n + {4'd0, m[127 - 8 * k]};
    end
    return n;
  endfunction

  // item payload, hash key H, the pending result and the output register fields
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      blk_q  <= in_blk;
      mask_q <= in_mask;
      emit_q <= (in_op == agc_pkg::OP_DATA);
    end
    if (state_q == agc_pkg::ST_HKEY && aes_done) begin
      h_q <= aes_res;
    end
    if (state_q == agc_pkg::ST_DATA_AES && aes_done) begin
      res_q       <= data_out;
      res_kind_q  <= agc_pkg::KIND_DATA;
      res_bytes_q <= in_nb_q_bytes(mask_q);
      res_ok_q    <= 1'b0;
    end
    if (state_q == agc_pkg::ST_TAG_MUL && gf_done) begin
      res_q <= gf_z;
    end
    if (state_q == agc_pkg::ST_TAG_AES && aes_done) begin
      if (enc_q) begin
        res_q       <= tag_val;
        res_kind_q  <= agc_pkg::KIND_TAG;
        res_bytes_q <= tlen_q;
        res_ok_q    <= 1'b0;
      end else begin
        res_q       <= '0;
        res_kind_q  <= agc_pkg::KIND_STATUS;
        res_bytes_q <= 5'd0;
        res_ok_q    <= (tag_val == (blk_q & tag_keep));
      end
    end
    if (state_q == agc_pkg::ST_OUT && state_d == agc_pkg::ST_IDLE) begin
      out_kind_q  <= res_kind_q;
      out_blk_q   <= res_q;
      out_bytes_q <= res_bytes_q;
      out_ok_q    <= res_ok_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {2'b00, out_ok_q, out_bytes_q, out_blk_q[63:0], out_blk_q[127:64]};

  agc_key_sched u_key_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ks_start),
    .key_i      ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .key_size_i (ksize_q),
    .done_o     (ks_done),
    .rd_addr_i  (rk_addr),
    .rd_data_o  (rk_row)
  );

  agc_aes_core u_aes (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (aes_start),
    .blk_i     (aes_blk),
    .nr_i      (nr),
    .rk_addr_o (rk_addr),
    .rk_i      (rk_row),
    .done_o    (aes_done),
    .res_o     (aes_res)
  );

  agc_gf_mul u_gf_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gf_start),
    .x_i     (gf_x),
    .y_i     (h_q),
    .done_o  (gf_done),
    .z_o     (gf_z)
  );

endmodule
`default_nettype wire
